### rtl/clbw_pkg.sv
// Package for the character LCD bus writer: request, byte and bus-write types,
// operation codes, step codes and the cursor address function. No dependencies.
package clbw_pkg;

  // Request operations
  localparam logic [1:0] OP_COMMAND   = 2'd0;
  localparam logic [1:0] OP_CHAR      = 2'd1;
  localparam logic [1:0] OP_CHAR_AT   = 2'd2;
  localparam logic [1:0] OP_GLYPH     = 2'd3;

  // Front-end step codes; glyph rows use steps 1 to 8
  localparam logic [3:0] STEP_CGRAM   = 4'd0;
  localparam logic [3:0] STEP_ROW_END = 4'd8;
  localparam logic [3:0] STEP_CURSOR  = 4'd9;
  localparam logic [3:0] STEP_FINAL   = 4'd10;

  localparam logic [7:0] CGRAM_BASE   = 8'h40;
  localparam logic [7:0] ROW1_BASE    = 8'h80;
  localparam logic [7:0] ROW2_BASE    = 8'hC0;
  localparam logic [7:0] ROW3_BASE    = 8'h94;
  localparam logic [7:0] ROW4_BASE    = 8'hD4;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  byte_value;
    logic [2:0]  row;
    logic [5:0]  column;
    logic [63:0] glyph;
    logic [2:0]  slot;
  } lcd_req_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_value;
    logic       last;
  } lcd_wr_t;

  // One byte bound for the LCD, as queued between front and back
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic row_known(input logic [2:0] row);
    return (row >= 3'd1) && (row <= 3'd4);
  endfunction

  // Row base plus column minus one, modulo 256
  function automatic logic [7:0] cursor_addr(input logic [2:0] row, input logic [5:0] column);
    logic [7:0] base;
    base = ROW1_BASE;
    unique case (row)
      3'd2:    base = ROW2_BASE;
      3'd3:    base = ROW3_BASE;
      3'd4:    base = ROW4_BASE;
      default: base = ROW1_BASE;
    endcase
    return base + {2'b00, column} + 8'hFF;
  endfunction

endpackage

### rtl/clbw_front.sv
// Front end: accepts LCD requests and expands each into its run of bytes.
// Depends on clbw_pkg; pushes byte words into clbw_queue.
module clbw_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  clbw_pkg::lcd_req_t    in_data,
  input  clbw_pkg::queue_stat_t q_stat,
  output logic                  push,
  output clbw_pkg::byte_word_t  push_word
);
  import clbw_pkg::*;

  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  lcd_req_t   req_r;
  logic       cur_last;
  logic       accept;
  logic [3:0] start_step;
  logic [2:0] glyph_idx;

  assign cur_last = (step_r == STEP_FINAL);
  assign push     = busy_r && !q_stat.full;
  assign in_ready = !busy_r || (push && cur_last);
  assign accept   = in_valid && in_ready;

  // First step of a new request
  always_comb begin
    unique case (in_data.operation)
      OP_GLYPH:   start_step = STEP_CGRAM;
      OP_CHAR_AT: start_step = row_known(in_data.row) ? STEP_CURSOR : STEP_FINAL;
      default:    start_step = STEP_FINAL;
    endcase
  end

  // Byte for the current step
  assign glyph_idx = 3'(step_r - 4'd1);
  always_comb begin
    push_word.last = cur_last;
    case (step_r)
      STEP_CGRAM: begin
        push_word.rs    = RS_CMD;
        push_word.value = CGRAM_BASE + {2'b00, req_r.slot, 3'b000};
      end
      STEP_CURSOR: begin
        push_word.rs    = RS_CMD;
        push_word.value = cursor_addr(req_r.row, req_r.column);
      end
      STEP_FINAL: begin
        push_word.rs    = (req_r.operation == OP_COMMAND) ? RS_CMD : RS_DATA;
        push_word.value = (req_r.operation == OP_GLYPH) ? {5'd0, req_r.slot}
                                                        : req_r.byte_value;
      end
      default: begin
        push_word.rs    = RS_DATA;
        push_word.value = req_r.glyph[{glyph_idx, 3'b000} +: 8];
      end
    endcase
  end

  // Step sequencing
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (push) begin
      if (cur_last) begin
        busy_nxt = 1'b0;
      end else if (step_r == STEP_ROW_END) begin
        step_nxt = row_known(req_r.row) ? STEP_CURSOR : STEP_FINAL;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = start_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_FINAL;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

endmodule

### rtl/clbw_queue.sv
// Short byte queue between the front and back ends.
// Depends on clbw_pkg for the byte word and status types.
module clbw_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clbw_pkg::byte_word_t  push_word,
  input  logic                  pop,
  output clbw_pkg::byte_word_t  head,
  output clbw_pkg::queue_stat_t stat
);
  import clbw_pkg::*;

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  byte_word_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### rtl/clbw_back.sv
// Back end: turns queued bytes into byte or nibble bus writes in the output register.
// Depends on clbw_pkg; pops byte words from clbw_queue.
module clbw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  nibble_mode,
  input  clbw_pkg::byte_word_t  head,
  input  clbw_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output clbw_pkg::lcd_wr_t     out_data
);
  import clbw_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  lcd_wr_t out_data_r, out_data_nxt;
  logic    low_half_r, low_half_nxt;
  logic    load;

  assign load = (!out_valid_r || out_ready) && !q_stat.empty;

  // Word selection: high nibble, low nibble or whole byte
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    low_half_nxt  = low_half_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.register_select = head.rs;
      if (!nibble_mode) begin
        out_data_nxt.bus_value = head.value;
        out_data_nxt.last      = head.last;
        pop                    = 1'b1;
      end else if (!low_half_r) begin
        out_data_nxt.bus_value = {4'd0, head.value[7:4]};
        out_data_nxt.last      = 1'b0;
        low_half_nxt           = 1'b1;
      end else begin
        out_data_nxt.bus_value = {4'd0, head.value[3:0]};
        out_data_nxt.last      = head.last;
        low_half_nxt           = 1'b0;
        pop                    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      low_half_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      low_half_r  <= low_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/char_lcd_bus_writer.sv
// Top level of the character LCD bus writer: front end, byte queue, back end.
// Depends on clbw_pkg, clbw_front, clbw_queue and clbw_back.
//
// Each request turns into a run of bus writes, one write per enable pulse,
// with last set on the final write. The front end pushes the bytes that a
// request produces (1 for a command or character, 1 or 2 for a positioned
// character, 10 or 11 for a custom glyph) into the queue, holding while the
// queue is full, and accepts the next request in the cycle its final byte
// enters the queue. The back end register issues one bus write per cycle
// while out_ready is high and the queue is not empty, two per byte in 4-bit
// mode. The first write of a request passes the front end's request and step
// registers, the queue and the back end's output register before it shows
// on out_valid. nibble_mode resets to 1 (4-bit writes); write it only while
// no request is in flight.
module char_lcd_bus_writer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clbw_pkg::lcd_req_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clbw_pkg::lcd_wr_t  out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import clbw_pkg::*;

  logic        nibble_mode_r;
  logic        push, pop;
  byte_word_t  push_word, head;
  queue_stat_t q_stat;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      nibble_mode_r <= cfg_wr_data;
    end
  end

  clbw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  clbw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  clbw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .nibble_mode (nibble_mode_r),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

### rtl/clbw_checker.sv
// Port-level checks for char_lcd_bus_writer, attached by bind.
// Depends on clbw_pkg and the top level's ports.
module clbw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input clbw_pkg::lcd_req_t in_data,
  input logic               out_valid,
  input logic               out_ready,
  input clbw_pkg::lcd_wr_t  out_data,
  input logic               cfg_wr_en,
  input logic               cfg_wr_data
);
  import clbw_pkg::*;

  logic mode_r;
  logic half_r;

  // Shadow of the mode register and of the nibble phase seen at the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      half_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (out_valid && out_ready && mode_r) half_r <= !half_r;
    end
  end

  // A waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  // A stalled write holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // Nibble writes keep the upper lines at zero
  a_nibble_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r |-> out_data.bus_value[7:4] == 4'd0)
    else $error("upper bits set in 4-bit mode");

  // A high nibble never closes a request
  a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r && !half_r |-> !out_data.last)
    else $error("last set on a high nibble");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind char_lcd_bus_writer clbw_checker u_clbw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

### test/char_lcd_bus_writer_test.sv
// Testbench for char_lcd_bus_writer: drives LCD requests, predicts every bus write
// and checks each one as it leaves the block. Depends on clbw_pkg and the RTL.
module char_lcd_bus_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clbw_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // quiet cycles after the last write
  localparam int DRAIN_LIMIT   = 4000;  // cycles allowed for writes to drain
  localparam int MAX_REPORTS   = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lcd_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lcd_wr_t  out_data;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;

  // Predictor state: bus writes still owed by the block, and its mode copy
  lcd_wr_t  pending_writes[$];
  logic     four_bit_mode = 1'b1;
  bit       steady_run = 1'b0;   // no idling on either side while set
  int       error_count = 0;

  char_lcd_bus_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("char_lcd_bus_writer_test: errors");
    $finish;
  end

  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // One byte becomes one 8-bit write or two nibble writes, high nibble first
  function automatic void push_byte(input logic rs, input logic [7:0] b);
    lcd_wr_t w;
    if (four_bit_mode) begin
      w = '{register_select: rs, bus_value: {4'h0, b[7:4]}, last: 1'b0};
      pending_writes.push_back(w);
      w.bus_value = {4'h0, b[3:0]};
      pending_writes.push_back(w);
    end else begin
      w = '{register_select: rs, bus_value: b, last: 1'b0};
      pending_writes.push_back(w);
    end
  endfunction

  // Set-DDRAM command for a row/column; rows outside 1..4 send nothing
  function automatic void push_cursor(input logic [2:0] row, input logic [5:0] col);
    logic [7:0] base;
    logic       known;
    known = 1'b1;
    base  = ROW1_BASE;
    case (row)
      3'd1:    base = ROW1_BASE;
      3'd2:    base = ROW2_BASE;
      3'd3:    base = ROW3_BASE;
      3'd4:    base = ROW4_BASE;
      default: known = 1'b0;
    endcase
    if (known) push_byte(RS_CMD, base + {2'b00, col} - 8'd1);
  endfunction

  function automatic void expand_request(input lcd_req_t req);
    lcd_wr_t tail;
    case (req.operation)
      OP_COMMAND: push_byte(RS_CMD, req.byte_value);
      OP_CHAR:    push_byte(RS_DATA, req.byte_value);
      OP_CHAR_AT: begin
        push_cursor(req.row, req.column);
        push_byte(RS_DATA, req.byte_value);
      end
      OP_GLYPH: begin
        push_byte(RS_CMD, CGRAM_BASE + {2'b00, req.slot, 3'b000});
        for (int i = 0; i < 8; i++) push_byte(RS_DATA, req.glyph[8*i +: 8]);
        push_cursor(req.row, req.column);
        push_byte(RS_DATA, {5'b00000, req.slot});
      end
    endcase
    // every request ends in at least one write; flag the final one
    tail = pending_writes.pop_back();
    tail.last = 1'b1;
    pending_writes.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random backpressure and the write checker
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= steady_run ? 1'b1 : ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin : check_write
    lcd_wr_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_failure($sformatf("unexpected write: rs=%0b value=%02h last=%0b",
                                 out_data.register_select, out_data.bus_value,
                                 out_data.last));
      end else begin
        want = pending_writes.pop_front();
        if (out_data.register_select !== want.register_select ||
            out_data.bus_value !== want.bus_value ||
            out_data.last !== want.last)
          report_failure($sformatf(
            "write mismatch: expected rs=%0b value=%02h last=%0b, got rs=%0b value=%02h last=%0b",
            want.register_select, want.bus_value, want.last,
            out_data.register_select, out_data.bus_value, out_data.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Presents one request and returns at the edge it is taken, valid still high
  task automatic send_request(input lcd_req_t req);
    if (!steady_run) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    expand_request(req);
  endtask

  // Drop valid after the last request of a burst and let the writes drain
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_writes.size() != 0)
      report_failure($sformatf("%0d writes never arrived", pending_writes.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_nibble_mode(input logic mode);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    four_bit_mode = mode;
  endtask

  function automatic lcd_req_t make_req(input logic [1:0] op, input logic [7:0] bv,
                                        input logic [2:0] row, input logic [5:0] col,
                                        input logic [63:0] glyph, input logic [2:0] slot);
    lcd_req_t r;
    r = '{operation: op, byte_value: bv, row: row, column: col, glyph: glyph, slot: slot};
    return r;
  endfunction

  // Mostly well-placed cursors; some unknown rows and off-range columns
  function automatic lcd_req_t random_request();
    lcd_req_t r;
    r.operation  = 2'($urandom_range(3));
    r.byte_value = 8'($urandom_range(255));
    r.row        = ($urandom_range(99) < 80) ? 3'($urandom_range(4, 1))
                                             : 3'($urandom_range(7));
    r.column     = ($urandom_range(99) < 85) ? 6'($urandom_range(40))
                                             : 6'($urandom_range(63));
    r.glyph      = {$urandom, $urandom};
    r.slot       = 3'($urandom_range(7));
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset value of the mode is 4-bit: field extremes, every operation, cursor cases
  task automatic test_nibble_directed();
    send_request(make_req(OP_COMMAND, 8'h00, 3'd0, 6'd0, 64'h0, 3'd0));
    send_request(make_req(OP_COMMAND, 8'hFF, 3'd7, 6'd63, '1, 3'd7));
    send_request(make_req(OP_CHAR, 8'h00, 3'd0, 6'd0, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR, 8'hFF, 3'd7, 6'd63, '1, 3'd7));
    send_request(make_req(OP_CHAR_AT, 8'h41, 3'd1, 6'd1, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h42, 3'd2, 6'd40, 64'h0, 3'd0));
    // column 0 wraps to base minus one
    send_request(make_req(OP_CHAR_AT, 8'h43, 3'd3, 6'd0, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'hFF, 3'd4, 6'd63, '1, 3'd7));
    // unknown rows: character only
    send_request(make_req(OP_CHAR_AT, 8'h44, 3'd0, 6'd5, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h45, 3'd5, 6'd1, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h46, 3'd7, 6'd40, 64'h0, 3'd0));
    send_request(make_req(OP_GLYPH, 8'hFF, 3'd1, 6'd1, 64'h0, 3'd0));
    send_request(make_req(OP_GLYPH, 8'h00, 3'd4, 6'd40, '1, 3'd7));
    send_request(make_req(OP_GLYPH, 8'h5A, 3'd6, 6'd9, 64'h0123_4567_89AB_CDEF, 3'd3));
    send_request(make_req(OP_GLYPH, 8'hA5, 3'd2, 6'd0, 64'h8040_2010_0804_0201, 3'd5));
    wait_idle();
  endtask

  task automatic test_byte_directed();
    write_nibble_mode(1'b0);
    send_request(make_req(OP_COMMAND, 8'h01, 3'd0, 6'd0, 64'h0, 3'd0));
    send_request(make_req(OP_COMMAND, 8'hFF, 3'd7, 6'd63, '1, 3'd7));
    send_request(make_req(OP_CHAR, 8'h7E, 3'd1, 6'd1, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'hA5, 3'd4, 6'd40, 64'h0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h30, 3'd0, 6'd12, 64'h0, 3'd0));
    send_request(make_req(OP_GLYPH, 8'h00, 3'd3, 6'd20, '1, 3'd7));
    send_request(make_req(OP_GLYPH, 8'h00, 3'd0, 6'd0, 64'hAA55_AA55_0FF0_F00F, 3'd0));
    wait_idle();
  endtask

  task automatic test_random_traffic(input logic mode, input int count, input bit steady);
    write_nibble_mode(mode);
    steady_run = steady;
    repeat (count) send_request(random_request());
    wait_idle();
    steady_run = 1'b0;
  endtask

  // Short bursts with the mode set to a random value between them
  task automatic test_mode_switching(input int bursts);
    repeat (bursts) begin
      write_nibble_mode(1'($urandom_range(1)));
      repeat ($urandom_range(6, 2)) send_request(random_request());
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_nibble_directed();
    test_byte_directed();
    test_random_traffic(1'b1, 130, 1'b0);
    test_random_traffic(1'b0, 130, 1'b0);
    test_random_traffic(1'b1, 80, 1'b1);
    test_random_traffic(1'b0, 80, 1'b1);
    test_mode_switching(15);

    if (error_count == 0) begin
      $display("char_lcd_bus_writer_test: clean");
    end else begin
      $display("char_lcd_bus_writer_test: errors");
    end
    $finish;
  end

endmodule
